// ----- rtl/lkvc_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
package lkvc_pkg;

  localparam int KEY_W       = 16;
  localparam int VALUE_W     = 17;
  localparam int WAYS_W      = 7;
  localparam int STAMP_W     = 32;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 24;

  localparam logic [WAYS_W-1:0] WAYS_RESET = 7'd64;

  // Request kinds carried on in_tuser
  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } lkvc_state_t;

endpackage

// ----- rtl/lkvc_cell.sv -----
// One cache slot: holds valid/key/value/stamp and folds its entry into the scan token.
module lkvc_cell import lkvc_pkg::*; #(
  parameter  int ENTRIES  = 64,
  parameter  int CELL_IDX = 0,
  localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CW    = $clog2(ENTRIES + 1),
  localparam int NW    = (CW > WAYS_W) ? CW : WAYS_W,
  localparam int TOK_W = 1 + IW + VALUE_W + 1 + IW + 1 + STAMP_W + IW,
  localparam int WR_W  = 1 + 1 + 1 + IW + KEY_W + VALUE_W + STAMP_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [KEY_W-1:0]   lookup_key,
  input  logic [NW-1:0]      active_cnt,
  input  logic [STAMP_W-1:0] use_counter,
  input  logic [TOK_W-1:0]   tok_in,
  output logic [TOK_W-1:0]   tok_out,
  input  logic [WR_W-1:0]    wr_bus
);

  typedef struct packed {
    logic               found;
    logic [IW-1:0]      hit_idx;
    logic [VALUE_W-1:0] rd_value;
    logic               empty;
    logic [IW-1:0]      empty_idx;
    logic               have_best;
    logic [STAMP_W-1:0] best_age;
    logic [IW-1:0]      best_idx;
  } scan_tok_t;

  typedef struct packed {
    logic               en;
    logic               set_value;
    logic               set_key;
    logic [IW-1:0]      idx;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [STAMP_W-1:0] stamp;
  } wr_req_t;

  logic               valid_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;
  logic [STAMP_W-1:0] stamp_r;

  scan_tok_t          tin;
  scan_tok_t          tok_nxt;
  scan_tok_t          tok_r;
  wr_req_t            wr;
  logic               active;
  logic               wr_here;
  logic [STAMP_W-1:0] age;

  assign tin     = tok_in;
  assign wr      = wr_bus;
  assign tok_out = tok_r;
  assign active  = NW'(CELL_IDX) < active_cnt;
  assign wr_here = wr.en && (wr.idx == IW'(CELL_IDX));
  assign age     = use_counter - stamp_r;

  // Fold this slot into the token: first hit, first empty, oldest entry
  always_comb begin
    tok_nxt = tin;
    if (active) begin
      if (valid_r) begin
        if (!tin.found && key_r == lookup_key) begin
          tok_nxt.found    = 1'b1;
          tok_nxt.hit_idx  = IW'(CELL_IDX);
          tok_nxt.rd_value = value_r;
        end
        if (!tin.have_best || age > tin.best_age) begin
          tok_nxt.have_best = 1'b1;
          tok_nxt.best_age  = age;
          tok_nxt.best_idx  = IW'(CELL_IDX);
        end
      end else if (!tin.empty) begin
        tok_nxt.empty     = 1'b1;
        tok_nxt.empty_idx = IW'(CELL_IDX);
      end
    end
  end

  // Token stage toward the next cell
  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  // Slot valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (wr_here && wr.set_key) begin
      valid_r <= 1'b1;
    end
  end

  // Slot payload
  always_ff @(posedge clk) begin
    if (wr_here) begin
      stamp_r <= wr.stamp;
      if (wr.set_key) begin
        key_r <= wr.key;
      end
      if (wr.set_value) begin
        value_r <= wr.value;
      end
    end
  end

endmodule

// ----- rtl/lru_key_value_cache.sv -----
// Top level of the fully associative LRU key-value cache.
// Fully associative get/put cache of ENTRIES slots with least-recently-used
// replacement; the ways_in_use register limits the active slots (0 acts as 1,
// values above ENTRIES act as ENTRIES). One request is worked at a time: a scan
// token walks the row of slot cells one cell per cycle, collecting the first
// key match, the first empty slot and the oldest entry, and then a single write
// cycle updates the chosen slot and loads the result register. The length of
// the scan is set by the length of the cell row, and a new request is taken
// only after the write; the next request is taken while a result waits.
// Results come back in request order. Recency is a 32-bit use stamp per slot.
module lru_key_value_cache import lkvc_pkg::*; #(
  parameter int ENTRIES = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // cfg: ways_in_use
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [WAYS_W-1:0]      cfg_data,
  // in_tdata: key [15:0], value [32:16], zero pad [39:33]
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: func (0 get, 1 put)
  input  logic                   in_tuser,
  // out_tdata: read_value [16:0], zero pad [23:17]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: hit
  output logic                   out_tuser
);

  localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW    = $clog2(ENTRIES + 1);
  localparam int NW    = (CW > WAYS_W) ? CW : WAYS_W;
  localparam int TOK_W = 1 + IW + VALUE_W + 1 + IW + 1 + STAMP_W + IW;
  localparam int WR_W  = 1 + 1 + 1 + IW + KEY_W + VALUE_W + STAMP_W;

  typedef struct packed {
    logic               found;
    logic [IW-1:0]      hit_idx;
    logic [VALUE_W-1:0] rd_value;
    logic               empty;
    logic [IW-1:0]      empty_idx;
    logic               have_best;
    logic [STAMP_W-1:0] best_age;
    logic [IW-1:0]      best_idx;
  } scan_tok_t;

  typedef struct packed {
    logic               en;
    logic               set_value;
    logic               set_key;
    logic [IW-1:0]      idx;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic [STAMP_W-1:0] stamp;
  } wr_req_t;

  lkvc_state_t        state_r, state_nxt;
  logic [CW-1:0]      scan_cnt_r, scan_cnt_nxt;
  logic [WAYS_W-1:0]  ways_r;
  logic [STAMP_W-1:0] use_cnt_r;
  logic               func_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] value_r;
  logic               out_valid_r;
  logic               out_hit_r;
  logic [VALUE_W-1:0] out_value_r;

  logic [NW-1:0]      active_cnt;
  logic [NW-1:0]      ways_ext;
  logic               in_fire;
  logic               done_fire;
  scan_tok_t          last_tok;
  wr_req_t            wr;
  logic [TOK_W-1:0]   tok_chain [ENTRIES+1];

  // Effective slot count
  assign ways_ext = NW'(ways_r);
  always_comb begin
    if (ways_r == '0) begin
      active_cnt = NW'(1);
    end else if (ways_ext > NW'(ENTRIES)) begin
      active_cnt = NW'(ENTRIES);
    end else begin
      active_cnt = ways_ext;
    end
  end

  // Configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_r <= WAYS_RESET;
    end else if (cfg_valid) begin
      ways_r <= cfg_data;
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign done_fire = (state_r == ST_WRITE) && (!out_valid_r || out_tready);

  // Sequencer: idle, scan across the cell row, write back
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt    = ST_SCAN;
          scan_cnt_nxt = '0;
        end
      end
      ST_SCAN: begin
        scan_cnt_nxt = scan_cnt_r + CW'(1);
        if (scan_cnt_r == CW'(ENTRIES - 1)) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (done_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r  <= in_tuser;
      key_r   <= in_tdata[KEY_W-1:0];
      value_r <= in_tdata[KEY_W +: VALUE_W];
    end
  end

  // Write-back decision from the token leaving the last cell
  assign last_tok = tok_chain[ENTRIES];
  always_comb begin
    wr           = '0;
    wr.key       = key_r;
    wr.value     = value_r;
    wr.stamp     = use_cnt_r + STAMP_W'(1);
    wr.idx       = last_tok.hit_idx;
    if (done_fire) begin
      if (func_r == FUNC_PUT) begin
        wr.en        = 1'b1;
        wr.set_value = 1'b1;
        wr.set_key   = !last_tok.found;
        if (!last_tok.found) begin
          wr.idx = last_tok.empty ? last_tok.empty_idx : last_tok.best_idx;
        end
      end else begin
        wr.en = last_tok.found;
      end
    end
  end

  // Use counter advances on every touch
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_cnt_r <= '0;
    end else if (wr.en) begin
      use_cnt_r <= wr.stamp;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done_fire) begin
      out_hit_r   <= last_tok.found;
      out_value_r <= (func_r == FUNC_GET && last_tok.found) ? last_tok.rd_value : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tdata  = OUT_TDATA_W'(out_value_r);

  // Row of slot cells
  assign tok_chain[0] = '0;
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lkvc_cell #(
      .ENTRIES  (ENTRIES),
      .CELL_IDX (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .lookup_key  (key_r),
      .active_cnt  (active_cnt),
      .use_counter (use_cnt_r),
      .tok_in      (tok_chain[g]),
      .tok_out     (tok_chain[g+1]),
      .wr_bus      (wr)
    );
  end

endmodule
